// ----- hdl/b2dt_pkg.sv -----
package b2dt_pkg;

  localparam int FRAC_W    = 6;
  localparam int BUF_W     = 7;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUF  = 2'd1;

  localparam logic [FRAC_W-1:0] FRAC_RST   = 6'd24;
  localparam int                FRAC_LIMIT = 38;
  localparam logic [FRAC_W-1:0] FRAC_MAX   = 6'd38;
  localparam logic [BUF_W-1:0]  BUF_RST    = 7'd64;

  localparam int MAX_CHARS   = 40;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  typedef struct packed {
    logic [FRAC_W-1:0] frac;
    logic [BUF_W-1:0]  bufsz;
  } cfg_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } res_t;

endpackage

// ----- hdl/b2dt_front.sv -----
module b2dt_front #(
  parameter int AMOUNT_BYTES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [7:0]                byte_i,
  input  logic                      last_i,
  output logic                      push_o,
  output logic [8*AMOUNT_BYTES-1:0] amount_o
);
  import b2dt_pkg::*;

  localparam int NB = 8 * AMOUNT_BYTES;
  localparam int IW = $clog2(AMOUNT_BYTES + 1);

  logic [NB-1:0] amt_q;
  logic [NB-1:0] merged;
  logic [IW-1:0] idx_q;

  // byte lands at its slot; past the end nothing matches
  always_comb begin
    for (int j = 0; j < AMOUNT_BYTES; j++) begin
      merged[j*8 +: 8] = (idx_q == IW'(j)) ? byte_i : amt_q[j*8 +: 8];
    end
  end

  assign push_o   = accept_i & last_i;
  assign amount_o = merged;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amt_q <= '0;
      idx_q <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        amt_q <= '0;
        idx_q <= '0;
      end else begin
        amt_q <= merged;
        if (idx_q < IW'(AMOUNT_BYTES)) begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/b2dt_fifo.sv -----
module b2dt_fifo #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);
  import b2dt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [AW-1:0]               wr_q, rd_q;
  logic [CW-1:0]               cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/b2dt_back.sv -----
module b2dt_back #(
  parameter int AMOUNT_BYTES   = 16,
  parameter int SCRATCH_DIGITS = 42
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  b2dt_pkg::cfg_t            cfg_i,
  input  logic                      q_valid_i,
  input  logic [8*AMOUNT_BYTES-1:0] q_data_i,
  output logic                      q_pop_o,
  output logic                      res_valid_o,
  output b2dt_pkg::res_t            res_o
);
  import b2dt_pkg::*;

  localparam int NB     = 8 * AMOUNT_BYTES;
  localparam int ND_RAW = NB / 3;
  localparam int ND     = (ND_RAW > SCRATCH_DIGITS) ? SCRATCH_DIGITS : ND_RAW;
  localparam int DW     = (ND > FRAC_LIMIT + 1) ? ND : FRAC_LIMIT + 1;
  localparam int PW     = $clog2(DW);
  localparam int BCW    = $clog2(NB + 1);
  localparam int CW     = 8;
  localparam int NCW    = $clog2(MAX_CHARS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_CHECK,
    ST_ALIGN,
    ST_EMIT
  } st_e;

  st_e                  state_q;
  logic [NB-1:0]        amt_q;
  logic [BCW-1:0]       bcnt_q;
  logic [DW-1:0][3:0]   dig_q;
  logic [PW-1:0]        sp_q, hi_q, lo_q, pos_q, e_q;
  logic [FRAC_W-1:0]    fr_q;
  logic                 any_q, dot_q;
  logic [NCW-1:0]       nout_q;
  logic                 res_valid_q;
  res_t                 res_q;

  // one double dabble step: add 3 where digit >= 5, then shift left
  logic [ND-1:0][3:0]   adj;
  logic [DW-1:0][3:0]   conv_d;

  always_comb begin
    conv_d = '0;
    for (int k = 0; k < ND; k++) begin
      adj[k] = (dig_q[k] >= 4'd5) ? 4'(dig_q[k] + 4'd3) : dig_q[k];
    end
    conv_d[0] = {adj[0][2:0], amt_q[NB-1]};
    for (int k = 1; k < ND; k++) begin
      conv_d[k] = {adj[k][2:0], adj[k-1][3]};
    end
  end

  // length check and text layout
  logic [FRAC_W-1:0] fr;
  logic [CW-1:0]     len_w, fr_w, tlen_w, bs_w;
  logic              err, has_frac;
  logic [PW-1:0]     top, e_pos, align_cnt;

  always_comb begin
    fr       = (cfg_i.frac > FRAC_MAX) ? FRAC_MAX : cfg_i.frac;
    len_w    = any_q ? CW'(hi_q) + CW'(1) : CW'(1);
    fr_w     = CW'(fr);
    bs_w     = CW'(cfg_i.bufsz);
    tlen_w   = (len_w <= fr_w) ? fr_w + CW'(2) : len_w + CW'(1);
    err      = (CW'(ND) >= bs_w) || (len_w + CW'(2) > bs_w) || (tlen_w + CW'(1) > bs_w);
    top      = (len_w > fr_w) ? PW'(len_w - CW'(1)) : PW'(fr);
    has_frac = any_q && (CW'(lo_q) < fr_w);
    e_pos    = has_frac ? lo_q : PW'(fr);
    align_cnt = PW'(DW - 1) - top;
  end

  logic [7:0] digit_ch;
  logic       nat_last, cap_last;

  assign digit_ch = CHAR_ZERO + {4'h0, dig_q[DW-1]};
  assign nat_last = (pos_q == e_q);
  assign cap_last = (nout_q == NCW'(MAX_CHARS - 1));

  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      amt_q       <= '0;
      bcnt_q      <= '0;
      dig_q       <= '0;
      sp_q        <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      pos_q       <= '0;
      e_q         <= '0;
      fr_q        <= '0;
      any_q       <= 1'b0;
      dot_q       <= 1'b0;
      nout_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            amt_q   <= q_data_i;
            dig_q   <= '0;
            bcnt_q  <= BCW'(NB);
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          dig_q  <= conv_d;
          amt_q  <= {amt_q[NB-2:0], 1'b0};
          bcnt_q <= bcnt_q - 1'b1;
          if (bcnt_q == BCW'(1)) begin
            sp_q    <= PW'(DW - 1);
            any_q   <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // full rotation, top slot walks from highest position down
          dig_q <= {dig_q[DW-2:0], dig_q[DW-1]};
          if (dig_q[DW-1] != 4'h0) begin
            if (!any_q) begin
              hi_q <= sp_q;
            end
            lo_q  <= sp_q;
            any_q <= 1'b1;
          end
          if (sp_q == '0) begin
            state_q <= ST_CHECK;
          end else begin
            sp_q <= sp_q - 1'b1;
          end
        end
        ST_CHECK: begin
          if (err) begin
            res_valid_q <= 1'b1;
            res_q       <= '{ch: 8'h00, last: 1'b1, err: 1'b1};
            state_q     <= ST_IDLE;
          end else begin
            sp_q    <= align_cnt;
            pos_q   <= top;
            fr_q    <= fr;
            e_q     <= e_pos;
            dot_q   <= 1'b0;
            nout_q  <= '0;
            state_q <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          if (sp_q == '0) begin
            state_q <= ST_EMIT;
          end else begin
            dig_q <= {dig_q[DW-2:0], 4'h0};
            sp_q  <= sp_q - 1'b1;
          end
        end
        ST_EMIT: begin
          res_valid_q <= 1'b1;
          nout_q      <= nout_q + 1'b1;
          if (dot_q) begin
            res_q <= '{ch: CHAR_DOT, last: cap_last, err: 1'b0};
            dot_q <= 1'b0;
            if (cap_last) begin
              state_q <= ST_IDLE;
            end
          end else begin
            res_q <= '{ch: digit_ch, last: nat_last || cap_last, err: 1'b0};
            dig_q <= {dig_q[DW-2:0], 4'h0};
            pos_q <= pos_q - 1'b1;
            if (nat_last || cap_last) begin
              state_q <= ST_IDLE;
            end else if (pos_q == PW'(fr_q)) begin
              dot_q <= 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/binary_amount_to_decimal_text_top.sv -----
// binary amount to decimal text
// input: one byte per transfer (start high while busy low), least significant
// byte first, byte_last_i marks the final byte; bytes past AMOUNT_BYTES are
// dropped, missing bytes count as zero
// config: cfg_valid_i/cfg_ready_o with cfg_index_i (0 frac_digits, 1 buffer_size)
// and cfg_data_i; ready is always high, write only while the block is idle
// output: one character per out_valid_o pulse, char_last_o on the final one;
// a too small buffer gives a single result with format_error_o and char zero
// steps: for each queued amount, a double dabble conversion of all 8*AMOUNT_BYTES
// bits at one bit per cycle, a digit scan over every digit slot, a length check
// (an error result is given here), a shift that aligns the top digit, then up
// to 40 characters back to back
// queue: a two-entry queue holds finished amounts so the byte side keeps
// taking input while the converter works; busy is high only when it is full
// reset: frac_digits 24, buffer_size 64, queue empty, converter idle
// results cannot be held off by the receiver; each is shown for one cycle
module binary_amount_to_decimal_text_top #(
  parameter int AMOUNT_BYTES   = 16,
  parameter int SCRATCH_DIGITS = 42
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [7:0]                       amount_byte_i,
  input  logic                             byte_last_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [b2dt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [b2dt_pkg::BUF_W-1:0]       cfg_data_i,
  output logic                             out_valid_o,
  output logic [7:0]                       out_char_o,
  output logic                             char_last_o,
  output logic                             format_error_o
);
  import b2dt_pkg::*;

  localparam int NB = 8 * AMOUNT_BYTES;

  // configuration registers
  logic [FRAC_W-1:0] frac_q;
  logic [BUF_W-1:0]  buf_q;
  cfg_t              cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= FRAC_RST;
      buf_q  <= BUF_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // other indexes are ignored
      if (cfg_index_i == REG_FRAC) begin
        frac_q <= cfg_data_i[FRAC_W-1:0];
      end else if (cfg_index_i == REG_BUF) begin
        buf_q <= cfg_data_i;
      end
    end
  end

  assign cfg = '{frac: frac_q, bufsz: buf_q};

  // front: gather bytes, hand a full amount to the queue on the last byte
  logic          accept;
  logic          push;
  logic [NB-1:0] push_data;
  logic          q_full, q_valid, q_pop;
  logic [NB-1:0] q_data;

  assign accept = start && !busy;
  assign busy   = q_full;

  b2dt_front #(
    .AMOUNT_BYTES(AMOUNT_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (amount_byte_i),
    .last_i  (byte_last_i),
    .push_o  (push),
    .amount_o(push_data)
  );

  // queue of finished amounts between byte side and converter
  b2dt_fifo #(
    .WIDTH(NB),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (q_data)
  );

  // back: double dabble, scan, format and emit
  logic res_valid;
  res_t res;

  b2dt_back #(
    .AMOUNT_BYTES  (AMOUNT_BYTES),
    .SCRATCH_DIGITS(SCRATCH_DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign out_valid_o    = res_valid;
  assign out_char_o     = res.ch;
  assign char_last_o    = res.last;
  assign format_error_o = res.err;

  // error result is a lone zero character marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && format_error_o |-> char_last_o && (out_char_o == 8'h00))
    else $error("error result not a lone last zero");

  // regular text holds only digits and the dot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !format_error_o |->
      (out_char_o == CHAR_DOT) || ((out_char_o >= CHAR_ZERO) && (out_char_o <= CHAR_NINE)))
    else $error("bad character in text");

  // a finished text is never followed directly by another transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_last_o |=> !out_valid_o)
    else $error("result right after end of text");

endmodule
